FILE: sv/column_block_minmax_int_assert.svh
// ----------------------------------------------------------------------------
// column_block_minmax_int assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef COLUMN_BLOCK_MINMAX_INT_ASSERT_SVH
`define COLUMN_BLOCK_MINMAX_INT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property at every clock edge outside reset
`define CBMM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition is followed by a consequence in the next cycle
`define CBMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CBMM_ASSERT(lbl, clk, rst_n, prop)
`define CBMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/cbmm_pkg.sv
// ----------------------------------------------------------------------------
// cbmm_pkg
// Shared types, codes and sizes of the column min/max block.
// ----------------------------------------------------------------------------
package cbmm_pkg;

    // Column type codes
    localparam logic [1:0] COL_INT32 = 2'd0;
    localparam logic [1:0] COL_INT64 = 2'd1;
    localparam logic [1:0] COL_FP32  = 2'd2;
    localparam logic [1:0] COL_FP64  = 2'd3;

    localparam logic [1:0] COL_TYPE_RESET = COL_INT64;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ALL_NULL = 1'b1;

    // Default queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // One decoded row between front and back
    typedef struct packed {
        logic signed [63:0] value;
        logic               is_null;
        logic               last_row;
    } t_row;

    // One zone-map result
    typedef struct packed {
        logic               status;
        logic signed [63:0] min_value;
        logic signed [63:0] max_value;
    } t_result;

endpackage

FILE: sv/column_block_minmax_int.sv
// ----------------------------------------------------------------------------
// column_block_minmax_int
// Zone-map min/max entry builder for one column of a block.
// ----------------------------------------------------------------------------
// Usage:
//   Rows enter on a queue-style port: a beat is taken at a clock edge with
//   push high and full low. Each beat carries the raw value bits, a null
//   flag and a last-row flag. Non-null rows are decoded per column_type
//   (int32, int64, float32 or float64 bits) and folded into min/max.
//   A last-row beat produces one result (status, min, max), read at the
//   result port: valid while empty is low, taken when pop is high.
//   column_type is written through i_cfg_valid/o_cfg_ready (always ready). The user
//   writes it only while idle; the block itself does not enforce this.
//   Throughput: one row per cycle while full is low, set by the min/max fold
//   register in the back end. A last row is registered in the front queue, then
//   its result in the result queue. When the receiver stalls, the result queue
//   fills, the back end holds at the next block end and the front queue fills
//   until full rises; rows in the middle of a block keep flowing while results wait.
//   Reset clears both queues and the running state; column_type returns to int64.
// ----------------------------------------------------------------------------
module column_block_minmax_int #(
    parameter int MID_DEPTH = cbmm_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = cbmm_pkg::OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_row_value,
    input  logic        i_is_null,
    input  logic        i_last_row,
    output logic        empty,
    input  logic        pop,
    output logic               o_status,
    output logic signed [63:0] o_min_value,
    output logic signed [63:0] o_max_value
);

    import cbmm_pkg::*;

    t_row    front_row;
    t_row    mid_row;
    logic    mid_empty;
    logic    mid_pop;
    t_result back_res;
    logic    back_push;
    logic    res_full;
    t_result out_res;

    assign o_cfg_ready = 1'b1;

    // Decode rows and hold the column type
    cbmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_row_value (i_row_value),
        .i_is_null   (i_is_null),
        .i_last_row  (i_last_row),
        .o_row       (front_row)
    );

    // Decouple front and back
    cbmm_queue #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(t_row))
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_row),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_row),
        .o_empty (mid_empty)
    );

    // Fold rows into min/max
    cbmm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row       (mid_row),
        .i_row_empty (mid_empty),
        .o_row_pop   (mid_pop),
        .o_res       (back_res),
        .o_res_push  (back_push),
        .i_res_full  (res_full)
    );

    // Hold results for the receiver
    cbmm_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_status    = out_res.status;
    assign o_min_value = out_res.min_value;
    assign o_max_value = out_res.max_value;

endmodule

FILE: sv/cbmm_queue.sv
// ----------------------------------------------------------------------------
// cbmm_queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`include "column_block_minmax_int_assert.svh"

module cbmm_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `CBMM_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `CBMM_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, wr_en && !rd_en,
                      r_count == $past(r_count) + 1'b1)
    `CBMM_ASSERT(a_ptr_match, i_clk, i_rst_n,
                 (r_wr_ptr == r_rd_ptr) == (r_count == '0 || r_count == CW'(DEPTH)))

endmodule

FILE: sv/cbmm_front.sv
// ----------------------------------------------------------------------------
// cbmm_front
// Holds the column type and decodes each row value to a signed 64-bit integer.
// ----------------------------------------------------------------------------
module cbmm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data,
    input  logic [63:0]   i_row_value,
    input  logic          i_is_null,
    input  logic          i_last_row,
    output cbmm_pkg::t_row o_row
);

    import cbmm_pkg::*;

    logic [1:0] r_column_type;

    // Decode raw bits by column type; floats truncate toward zero, saturate
    function automatic logic [63:0] f_decode(logic [1:0] ctype, logic [63:0] raw);
        logic        sgn;
        logic [10:0] expo;
        logic [51:0] frac;
        logic        expo_max;
        logic [10:0] bias;
        logic [10:0] ue;
        logic [63:0] sig;
        logic [63:0] mag;
        logic [63:0] sat;
        logic [63:0] res;
        sgn      = raw[63];
        expo     = raw[62:52];
        frac     = raw[51:0];
        expo_max = &raw[62:52];
        bias     = 11'd1023;
        res      = raw;
        if (ctype == COL_FP32) begin
            sgn      = raw[31];
            expo     = {3'b000, raw[30:23]};
            frac     = {raw[22:0], 29'd0};
            expo_max = &raw[30:23];
            bias     = 11'd127;
        end
        ue  = expo - bias;
        sig = {11'd0, 1'b1, frac};
        if (ue >= 11'd52) begin
            mag = sig << (ue - 11'd52);
        end else begin
            mag = sig >> (11'd52 - ue);
        end
        sat = sgn ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        case (ctype)
            COL_INT32: begin
                res = {{32{raw[31]}}, raw[31:0]};
            end
            COL_INT64: begin
                res = raw;
            end
            default: begin
                if (expo_max) begin
                    res = (frac != '0) ? 64'd0 : sat;
                end else if (expo < bias) begin
                    res = 64'd0;
                end else if (ue >= 11'd63) begin
                    res = sat;
                end else begin
                    res = sgn ? (64'd0 - mag) : mag;
                end
            end
        endcase
        return res;
    endfunction

    // Hold the column type between writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_type <= COL_TYPE_RESET;
        end else if (i_cfg_we) begin
            r_column_type <= i_cfg_data;
        end
    end

    // Classify the incoming row
    always_comb begin
        o_row.value    = $signed(f_decode(r_column_type, i_row_value));
        o_row.is_null  = i_is_null;
        o_row.last_row = i_last_row;
    end

endmodule

FILE: sv/cbmm_back.sv
// ----------------------------------------------------------------------------
// cbmm_back
// Folds decoded rows into the running min/max and emits one result per block.
// ----------------------------------------------------------------------------
module cbmm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbmm_pkg::t_row    i_row,
    input  logic              i_row_empty,
    output logic              o_row_pop,
    output cbmm_pkg::t_result o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);

    import cbmm_pkg::*;

    logic signed [63:0] r_min, n_min;
    logic signed [63:0] r_max, n_max;
    logic               r_seen, n_seen;
    logic signed [63:0] fold_min, fold_max;
    logic               fold_seen;

    // Pop unless a block end would find the result queue full
    assign o_row_pop  = !i_row_empty && (!i_row.last_row || !i_res_full);
    assign o_res_push = o_row_pop && i_row.last_row;

    // Fold one row
    always_comb begin
        fold_min  = r_min;
        fold_max  = r_max;
        fold_seen = r_seen;
        if (!i_row.is_null) begin
            fold_seen = 1'b1;
            if (!r_seen) begin
                fold_min = i_row.value;
                fold_max = i_row.value;
            end else begin
                if (i_row.value < r_min) begin
                    fold_min = i_row.value;
                end
                if (r_max < i_row.value) begin
                    fold_max = i_row.value;
                end
            end
        end
    end

    // Build the result and clear state at the block end
    always_comb begin
        o_res.status    = fold_seen ? STATUS_OK : STATUS_ALL_NULL;
        o_res.min_value = fold_seen ? fold_min : 64'sd0;
        o_res.max_value = fold_seen ? fold_max : 64'sd0;
        n_min  = r_min;
        n_max  = r_max;
        n_seen = r_seen;
        if (o_row_pop) begin
            if (i_row.last_row) begin
                n_min  = 64'sd0;
                n_max  = 64'sd0;
                n_seen = 1'b0;
            end else begin
                n_min  = fold_min;
                n_max  = fold_max;
                n_seen = fold_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= 64'sd0;
            r_max  <= 64'sd0;
            r_seen <= 1'b0;
        end else begin
            r_min  <= n_min;
            r_max  <= n_max;
            r_seen <= n_seen;
        end
    end

endmodule
